@@ rtl/ttok_pkg.sv @@
// ttok_pkg: shared types and constants of the text tokenizer
// item layouts, token kinds, scan mode codes, character codes and queue sizing
// no dependencies
`default_nettype none

package ttok_pkg;

  // input item: one source byte
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } token_in_t;

  // result item: one token
  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        end_of_run;
  } token_out_t;

  // at most this many tokens come out of one input item
  localparam int unsigned RES_MAX = 3;
  typedef token_out_t [RES_MAX-1:0] token_list_t;

  // character class flags
  typedef struct packed {
    logic       is_ws;
    logic       is_digit;
    logic       is_minus;
    logic       is_period;
    logic       is_punct;
    logic [4:0] punct_idx;
  } char_class_t;

  // token kinds
  localparam logic [5:0] KIND_END   = 6'd0;
  localparam logic [5:0] KIND_WS    = 6'd1;
  localparam logic [5:0] KIND_NUM   = 6'd2;
  localparam logic [5:0] KIND_TEXT  = 6'd3;
  localparam logic [5:0] KIND_PUNCT = 6'd4;
  localparam logic [5:0] KIND_MINUS = 6'd16;

  // scan modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_WS    = 3'd1;
  localparam logic [2:0] MODE_NUM   = 3'd2;
  localparam logic [2:0] MODE_TEXT  = 3'd3;
  localparam logic [2:0] MODE_MINUS = 3'd4;
  localparam logic [2:0] MODE_DONE  = 3'd5;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // result queue sizing
  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QPTR_W = 3;
  localparam int unsigned QCNT_W = 4;

  typedef struct packed {
    logic              space;
    logic [QCNT_W-1:0] level;
  } queue_stat_t;

endpackage

`default_nettype wire

@@ rtl/ttok_classify.sv @@
// ttok_classify: character class decode of one source byte
// depends on ttok_pkg
`default_nettype none

module ttok_classify import ttok_pkg::*; (
  input  logic [7:0]  ch_i,
  output char_class_t cls_o
);

  // punctuation table order, minus at 12 and period at 28
  function automatic logic [5:0] punct_lookup(input logic [7:0] c);
    logic [5:0] r;
    begin
      r = 6'd0;
      case (c)
        8'h60:   r = {1'b1, 5'd0};
        8'h7E:   r = {1'b1, 5'd1};
        8'h21:   r = {1'b1, 5'd2};
        8'h40:   r = {1'b1, 5'd3};
        8'h23:   r = {1'b1, 5'd4};
        8'h24:   r = {1'b1, 5'd5};
        8'h25:   r = {1'b1, 5'd6};
        8'h5E:   r = {1'b1, 5'd7};
        8'h26:   r = {1'b1, 5'd8};
        8'h2A:   r = {1'b1, 5'd9};
        8'h28:   r = {1'b1, 5'd10};
        8'h29:   r = {1'b1, 5'd11};
        8'h2D:   r = {1'b1, 5'd12};
        8'h5F:   r = {1'b1, 5'd13};
        8'h3D:   r = {1'b1, 5'd14};
        8'h2B:   r = {1'b1, 5'd15};
        8'h5B:   r = {1'b1, 5'd16};
        8'h7B:   r = {1'b1, 5'd17};
        8'h5D:   r = {1'b1, 5'd18};
        8'h7D:   r = {1'b1, 5'd19};
        8'h3B:   r = {1'b1, 5'd20};
        8'h3A:   r = {1'b1, 5'd21};
        8'h27:   r = {1'b1, 5'd22};
        8'h22:   r = {1'b1, 5'd23};
        8'h5C:   r = {1'b1, 5'd24};
        8'h7C:   r = {1'b1, 5'd25};
        8'h2C:   r = {1'b1, 5'd26};
        8'h3C:   r = {1'b1, 5'd27};
        8'h2E:   r = {1'b1, 5'd28};
        8'h3E:   r = {1'b1, 5'd29};
        8'h2F:   r = {1'b1, 5'd30};
        8'h3F:   r = {1'b1, 5'd31};
        default: r = 6'd0;
      endcase
      return r;
    end
  endfunction

  logic [5:0] pl;

  always_comb begin
    pl                = punct_lookup(ch_i);
    cls_o.is_ws       = (ch_i == CH_SPACE) || (ch_i == CH_LF) ||
                        (ch_i == CH_CR) || (ch_i == CH_TAB);
    cls_o.is_digit    = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
    cls_o.is_minus    = (ch_i == CH_MINUS);
    cls_o.is_period   = (ch_i == CH_PERIOD);
    cls_o.is_punct    = pl[5];
    cls_o.punct_idx   = pl[4:0];
  end

endmodule

`default_nettype wire

@@ rtl/ttok_scan.sv @@
// ttok_scan: token scanner state and per-item token generation
// depends on ttok_pkg; takes class flags from ttok_classify
`default_nettype none

module ttok_scan import ttok_pkg::*; #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  token_in_t   item_i,
  input  char_class_t cls_i,
  input  logic        skip_ws_i,
  output token_list_t res_o,
  output logic [1:0]  res_cnt_o
);

  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

  logic [2:0]          mode_q, mode_d;
  logic [POS_BITS-1:0] start_q, start_d;
  logic [POS_BITS-1:0] len_q, len_d;
  logic [POS_BITS-1:0] pos_q, pos_d;

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + POS_ONE;
  endfunction

  // positions leave the block masked to 16 bits
  function automatic logic [15:0] to16(input logic [POS_BITS-1:0] v);
    logic [POS_BITS+15:0] w;
    begin
      w = {16'd0, v};
      return w[15:0];
    end
  endfunction

  function automatic logic flush_valid(input logic [2:0] m, input logic skip);
    logic r;
    begin
      case (m)
        MODE_WS:    r = !skip;
        MODE_NUM:   r = 1'b1;
        MODE_TEXT:  r = 1'b1;
        MODE_MINUS: r = 1'b1;
        default:    r = 1'b0;
      endcase
      return r;
    end
  endfunction

  function automatic token_out_t flush_tok(input logic [2:0] m,
                                           input logic [POS_BITS-1:0] s,
                                           input logic [POS_BITS-1:0] l);
    token_out_t t;
    begin
      t.token_start  = to16(s);
      t.token_length = to16(l);
      t.end_of_run   = 1'b0;
      case (m)
        MODE_WS:   t.token_kind = KIND_WS;
        MODE_NUM:  t.token_kind = KIND_NUM;
        MODE_TEXT: t.token_kind = KIND_TEXT;
        MODE_MINUS: begin
          t.token_kind   = KIND_MINUS;
          t.token_length = 16'd1;
        end
        default:   t.token_kind = KIND_END;
      endcase
      return t;
    end
  endfunction

  // candidate tokens in emission order: flush, punct, final flush, end
  token_out_t          cand [4];
  logic [3:0]          cv;
  logic                grow;
  logic [2:0]          md;
  logic [POS_BITS-1:0] sd, ld, pos_n;

  always_comb begin
    cand[0] = flush_tok(mode_q, start_q, len_q);
    cv      = 4'b0000;
    grow    = 1'b0;
    md      = mode_q;
    sd      = start_q;
    ld      = len_q;
    pos_n   = sat_inc(pos_q);
    mode_d  = mode_q;
    start_d = start_q;
    len_d   = len_q;
    pos_d   = pos_q;

    cand[1].token_kind   = KIND_PUNCT + {1'b0, cls_i.punct_idx};
    cand[1].token_start  = to16(pos_q);
    cand[1].token_length = 16'd1;
    cand[1].end_of_run   = 1'b0;

    cand[3].token_kind   = KIND_END;
    cand[3].token_start  = to16(pos_q);
    cand[3].token_length = 16'd0;
    cand[3].end_of_run   = 1'b0;

    if (mode_q == MODE_DONE) begin
      // bytes after a zero are dropped until the last one
      if (item_i.last) begin
        mode_d  = MODE_IDLE;
        start_d = '0;
        len_d   = '0;
        pos_d   = '0;
      end
    end else if (item_i.ch == CH_NUL) begin
      cv[0] = flush_valid(mode_q, skip_ws_i);
      cv[3] = 1'b1;
      mode_d  = item_i.last ? MODE_IDLE : MODE_DONE;
      start_d = '0;
      len_d   = '0;
      if (item_i.last) begin
        pos_d = '0;
      end
    end else begin
      case (mode_q)
        MODE_WS:    grow = cls_i.is_ws;
        MODE_NUM:   grow = cls_i.is_digit || cls_i.is_period;
        MODE_TEXT:  grow = !cls_i.is_ws;
        MODE_MINUS: grow = cls_i.is_digit;
        default:    grow = 1'b0;
      endcase
      if (grow) begin
        md = (mode_q == MODE_MINUS) ? MODE_NUM : mode_q;
        ld = sat_inc(len_q);
      end else begin
        cv[0] = flush_valid(mode_q, skip_ws_i);
        sd    = pos_q;
        ld    = POS_ONE;
        if (cls_i.is_ws) begin
          md = MODE_WS;
        end else if (cls_i.is_digit) begin
          md = MODE_NUM;
        end else if (cls_i.is_minus) begin
          md = MODE_MINUS;
        end else if (cls_i.is_punct) begin
          cv[1] = 1'b1;
          md    = MODE_IDLE;
          sd    = '0;
          ld    = '0;
        end else begin
          md = MODE_TEXT;
        end
      end
      if (item_i.last) begin
        cv[2] = flush_valid(md, skip_ws_i);
        cv[3] = 1'b1;
        cand[3].token_start = to16(pos_n);
        mode_d  = MODE_IDLE;
        start_d = '0;
        len_d   = '0;
        pos_d   = '0;
      end else begin
        mode_d  = md;
        start_d = sd;
        len_d   = ld;
        pos_d   = pos_n;
      end
    end
    cand[2] = flush_tok(md, sd, ld);
  end

  // pack the valid candidates into consecutive slots
  logic [1:0] n;

  always_comb begin
    res_o = '0;
    n     = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (cv[i] && (n != 2'd3)) begin
        res_o[n] = cand[i];
        n        = n + 2'd1;
      end
    end
    for (int i = 0; i < RES_MAX; i++) begin
      res_o[i].end_of_run = (n != 2'd0) && (2'(i) == n - 2'd1);
    end
    res_cnt_o = fire_i ? n : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      start_q <= '0;
      len_q   <= '0;
      pos_q   <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ttok_queue.sv @@
// ttok_queue: result queue, up to three tokens in and one out per cycle
// depends on ttok_pkg
`default_nettype none

module ttok_queue import ttok_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  token_list_t push_i,
  input  logic [1:0]  push_cnt_i,
  input  logic        pop_i,
  output token_out_t  head_o,
  output queue_stat_t stat_o
);

  token_out_t        mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q + QCNT_W'(push_cnt_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < RES_MAX; i++) begin
      if (2'(i) < push_cnt_i) begin
        mem_q[wr_ptr_q + QPTR_W'(i)] <= push_i[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPTR_W'(push_cnt_i);
      rd_ptr_q <= rd_ptr_q + QPTR_W'(pop_i);
      cnt_q    <= cnt_d;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.level = cnt_q;
  assign stat_o.space = (cnt_q <= QCNT_W'(QDEPTH - RES_MAX));

endmodule

`default_nettype wire

@@ rtl/text_tokenizer.sv @@
// text_tokenizer: streaming lexical tokenizer, top level
// depends on ttok_pkg, ttok_classify, ttok_scan, ttok_queue
//
// The block takes one source byte per item and produces tokens (kind, start
// position, length) as soon as each is complete: whitespace runs, numbers,
// the 32 single punctuation characters and text. A zero byte or the item
// marked last ends the source; the open token is flushed and an end token
// follows, and end_of_run marks the last token caused by an item. An input
// item is accepted every cycle as long as the result queue has room for
// three tokens; the item waits in the input register until the queue has
// room, is then scanned into the queue, and its first token is offered at
// the queue head as soon as it is written there.
// Tokens leave at one per cycle while out_ready_i is high, so a stream whose
// items each cause at most one token runs at one item per clock, while items
// causing two or three tokens slow the input. The user sets skip_whitespace
// through cfg_we_i / cfg_wdata_i while no item is in flight (not enforced).
`default_nettype none

module text_tokenizer import ttok_pkg::*; #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  // character items
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  token_in_t  in_data_i,
  // token items
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output token_out_t out_data_o
);

  logic        skip_ws_q;
  logic        in_vld_q;
  token_in_t   in_q;
  logic        proc_fire;
  logic        pop;
  char_class_t cls;
  token_list_t res;
  logic [1:0]  res_cnt;
  queue_stat_t q_stat;

  // skip_whitespace register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_ws_q <= 1'b0;
    end else if (cfg_we_i) begin
      skip_ws_q <= cfg_wdata_i;
    end
  end

  // input register: scanned into the queue when three slots are free
  assign proc_fire  = in_vld_q && q_stat.space;
  assign in_ready_o = !in_vld_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // character class decode
  ttok_classify u_classify (
    .ch_i  (in_q.ch),
    .cls_o (cls)
  );

  // scanner state and token generation
  ttok_scan #(
    .POS_BITS (POS_BITS)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (proc_fire),
    .item_i    (in_q),
    .cls_i     (cls),
    .skip_ws_i (skip_ws_q),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  // result queue decouples bursts of up to three tokens from the output
  assign pop = out_valid_o && out_ready_i;

  ttok_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res),
    .push_cnt_i (res_cnt),
    .pop_i      (pop),
    .head_o     (out_data_o),
    .stat_o     (q_stat)
  );

  assign out_valid_o = (q_stat.level != '0);

  // queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.level <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  // an item that cannot be scanned stays in the input register unchanged
  a_input_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !proc_fire) |=> (in_vld_q && $stable(in_q)))
    else $error("input register lost a stalled item");

  // a pop with no push lowers the fill level by one
  a_pop_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (res_cnt == 2'd0)) |=> (q_stat.level == $past(q_stat.level) - QCNT_W'(1)))
    else $error("queue level did not follow a pop");

endmodule

`default_nettype wire
